// File: hdl/tpeq_pkg.sv
`timescale 1ns / 1ps

package tpeq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int HANDLER_W  = 16;
   localparam int ARGUMENT_W = 16;
   localparam int ENTRY_W    = HANDLER_W + ARGUMENT_W;
   localparam int TOTAL_W    = 6;

   // port widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 4;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic execute;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

// File: hdl/two_priority_event_queue.sv
// path: the request and head entries are registered at the transfer, then the result register is loaded
// flow: no new request is taken during the execute state, nor while a result is stalled;
//   in the execute state the head entries, read from the block memories at the transfer,
//   settle the result and the pointer and count updates
// reset: synchronous, active high; both queues empty, no result pending
`timescale 1ns / 1ps

module two_priority_event_queue #(
   parameter int QUEUE_DEPTH = tpeq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // handler_id [15:0], argument [31:16]
   input  logic [tpeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action [1:0], priority_req [2]
   input  logic [tpeq_pkg::REQ_TUSER_W-1:0] req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_handler_id [15:0], out_argument [31:16], total_count [37:32], zero fill [39:38]
   output logic [tpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // entry_valid [0], from_high [1], push_dropped [2], all_empty [3]
   output logic [tpeq_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   tpeq_pkg::cmd_type    cmd;
   tpeq_pkg::status_type status;

   // sequencer: idle, then an execute state after each request transfer
   tpeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // two ring stores, their pointers and counts, and the result register
   tpeq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hdl/tpeq_ctrl.sv
`timescale 1ns / 1ps

module tpeq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 rsp_tready,
   input  tpeq_pkg::status_type status,
   output tpeq_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      exec_ff;
   logic      exec_in;

   // idle, and the output slot is free, or its transfer happens at this edge
   assign req_tready = (state_ff == ST_IDLE) && (!status.rsp_busy || rsp_tready);

   always_comb begin
      state_in = state_ff;
      exec_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = ST_EXEC;
               exec_in  = 1'b1;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exec_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         exec_ff  <= exec_in;
      end
   end

   assign cmd.accept  = req_tvalid && req_tready;
   assign cmd.execute = exec_ff;

endmodule

// File: hdl/tpeq_datapath.sv
`timescale 1ns / 1ps

module tpeq_datapath #(
   parameter int QUEUE_DEPTH = tpeq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpeq_pkg::cmd_type                   cmd,
   output tpeq_pkg::status_type                status,
   input  logic [tpeq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [tpeq_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpeq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [tpeq_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int EXT_W = SUM_W + tpeq_pkg::TOTAL_W;
   localparam int ENT_W = tpeq_pkg::ENTRY_W;
   localparam int HID_W = tpeq_pkg::HANDLER_W;
   localparam int ARG_W = tpeq_pkg::ARGUMENT_W;

   logic [ENT_W-1:0] high_mem [QUEUE_DEPTH];
   logic [ENT_W-1:0] low_mem  [QUEUE_DEPTH];

   // captured request
   logic [tpeq_pkg::ACTION_W-1:0] action_ff;
   logic                          prio_ff;
   logic [HID_W-1:0]              hid_ff;
   logic signed [ARG_W-1:0]       arg_ff;

   // head entries read at accept
   logic [ENT_W-1:0] high_rd_ff;
   logic [ENT_W-1:0] low_rd_ff;

   logic [PTR_W-1:0] high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   logic [PTR_W-1:0] low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   logic [CNT_W-1:0] high_count_ff, high_count_in, low_count_ff, low_count_in;

   logic             high_wr, low_wr;
   logic             entry_valid, from_high, push_dropped;
   logic [ENT_W-1:0] entry_word;
   logic [SUM_W-1:0] total;
   logic [EXT_W-1:0] total_ext;

   logic                              rsp_tvalid_ff;
   logic [tpeq_pkg::RSP_TDATA_W-1:0]  rsp_tdata_ff;
   logic [tpeq_pkg::RSP_TUSER_W-1:0]  rsp_tuser_ff;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      res = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff  <= req_tuser[1:0];
         prio_ff    <= req_tuser[2];
         hid_ff     <= req_tdata[15:0];
         arg_ff     <= req_tdata[31:16];
         high_rd_ff <= high_mem[high_head_ff];
         low_rd_ff  <= low_mem[low_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (high_wr) begin
         high_mem[high_tail_ff] <= {hid_ff, arg_ff};
      end
      if (low_wr) begin
         low_mem[low_tail_ff] <= {hid_ff, arg_ff};
      end
   end

   always_comb begin
      high_head_in  = high_head_ff;
      high_tail_in  = high_tail_ff;
      high_count_in = high_count_ff;
      low_head_in   = low_head_ff;
      low_tail_in   = low_tail_ff;
      low_count_in  = low_count_ff;
      high_wr       = 1'b0;
      low_wr        = 1'b0;
      entry_valid   = 1'b0;
      from_high     = 1'b0;
      push_dropped  = 1'b0;
      entry_word    = '0;
      if (cmd.execute) begin
         unique case (action_ff)
            tpeq_pkg::ACT_PUSH: begin
               if (prio_ff) begin
                  if (high_count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     push_dropped = 1'b1;
                  end else begin
                     high_wr       = 1'b1;
                     high_tail_in  = wrap_next(high_tail_ff);
                     high_count_in = high_count_ff + 1'b1;
                  end
               end else begin
                  if (low_count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     push_dropped = 1'b1;
                  end else begin
                     low_wr       = 1'b1;
                     low_tail_in  = wrap_next(low_tail_ff);
                     low_count_in = low_count_ff + 1'b1;
                  end
               end
            end
            tpeq_pkg::ACT_POP, tpeq_pkg::ACT_PEEK: begin
               if (high_count_ff != '0) begin
                  entry_valid = 1'b1;
                  from_high   = 1'b1;
                  entry_word  = high_rd_ff;
                  if (action_ff == tpeq_pkg::ACT_POP) begin
                     high_head_in  = wrap_next(high_head_ff);
                     high_count_in = high_count_ff - 1'b1;
                  end
               end else if (low_count_ff != '0) begin
                  entry_valid = 1'b1;
                  entry_word  = low_rd_ff;
                  if (action_ff == tpeq_pkg::ACT_POP) begin
                     low_head_in  = wrap_next(low_head_ff);
                     low_count_in = low_count_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign total     = SUM_W'(high_count_in) + SUM_W'(low_count_in);
   assign total_ext = EXT_W'(total);

   always_ff @(posedge clock) begin
      if (reset) begin
         high_head_ff  <= '0;
         high_tail_ff  <= '0;
         high_count_ff <= '0;
         low_head_ff   <= '0;
         low_tail_ff   <= '0;
         low_count_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         high_head_ff  <= high_head_in;
         high_tail_ff  <= high_tail_in;
         high_count_ff <= high_count_in;
         low_head_ff   <= low_head_in;
         low_tail_ff   <= low_tail_in;
         low_count_ff  <= low_count_in;
         if (cmd.execute) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_tdata_ff <= {2'b00, total_ext[tpeq_pkg::TOTAL_W-1:0], entry_word[ARG_W-1:0],
                          entry_word[ENT_W-1:ARG_W]};
         rsp_tuser_ff <= {(high_count_in == '0) && (low_count_in == '0), push_dropped,
                          from_high, entry_valid};
      end
   end

   assign status.rsp_busy = rsp_tvalid_ff;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign rsp_tuser       = rsp_tuser_ff;

endmodule

// File: hdl/tpeq_checker.sv
`timescale 1ns / 1ps

module tpeq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tpeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [tpeq_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [tpeq_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // every request transfer yields an offered result once the execute state has loaded it
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing after request transfer");

   // one item in flight: no request transfer in the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during execute cycle");

   // no entry reported means zero entry fields and from_high clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[31:0] == '0) && !rsp_tuser[1])
      else $error("entry fields set without an entry");

   // both queues empty means a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> (rsp_tdata[37:32] == '0))
      else $error("empty flag with nonzero count");

endmodule

bind two_priority_event_queue tpeq_checker u_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH = tpeq_pkg::DEFAULT_QUEUE_DEPTH;
   // the one action code the block leaves unused
   localparam logic [tpeq_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
   // cycles the result side refuses transfers during the back-pressure test
   localparam int LONG_HOLD = 160;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 20000;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // handler_id [15:0], argument [31:16]
   logic [tpeq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   // action [1:0], priority_req [2]
   logic [tpeq_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // out_handler_id, out_argument, total_count
   logic [tpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   // entry_valid, from_high, push_dropped, all_empty
   logic [tpeq_pkg::RSP_TUSER_W-1:0] rsp_tuser;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;

   // mirrors both priority queues and keeps the results still to come, oldest first
   class event_queue_scoreboard;
      typedef logic [tpeq_pkg::ENTRY_W-1:0] entry_t;   // handler id above the argument
      typedef struct packed {
         logic                                   entry_valid;
         logic [tpeq_pkg::HANDLER_W-1:0]         handler;
         logic signed [tpeq_pkg::ARGUMENT_W-1:0] argument;
         logic                                   from_high;
         logic                                   push_dropped;
         logic [tpeq_pkg::TOTAL_W-1:0]           total;
         logic                                   all_empty;
      } result_t;

      entry_t  high_entries[$];
      entry_t  low_entries[$];
      result_t awaited_results[$];
      int      errors = 0;

      function int pending();
         return awaited_results.size();
      endfunction

      function void note_request(logic [tpeq_pkg::ACTION_W-1:0] act, logic prio,
                                 logic [tpeq_pkg::HANDLER_W-1:0] hid,
                                 logic [tpeq_pkg::ARGUMENT_W-1:0] arg);
         result_t res;
         entry_t  head;
         int      held;
         res = '0;
         case (act)
            tpeq_pkg::ACT_PUSH: begin
               if (prio) begin
                  if (high_entries.size() >= DEPTH) res.push_dropped = 1'b1;
                  else high_entries.push_back({hid, arg});
               end else begin
                  if (low_entries.size() >= DEPTH) res.push_dropped = 1'b1;
                  else low_entries.push_back({hid, arg});
               end
            end
            tpeq_pkg::ACT_POP, tpeq_pkg::ACT_PEEK: begin
               // strict priority: the high queue wins whenever it holds anything
               if (high_entries.size() != 0) begin
                  head = high_entries[0];
                  res.entry_valid = 1'b1;
                  res.from_high = 1'b1;
                  if (act == tpeq_pkg::ACT_POP) void'(high_entries.pop_front());
               end else if (low_entries.size() != 0) begin
                  head = low_entries[0];
                  res.entry_valid = 1'b1;
                  if (act == tpeq_pkg::ACT_POP) void'(low_entries.pop_front());
               end
               if (res.entry_valid) begin
                  res.handler = head[tpeq_pkg::ENTRY_W-1:tpeq_pkg::ARGUMENT_W];
                  res.argument = head[tpeq_pkg::ARGUMENT_W-1:0];
               end
            end
            default: ;
         endcase
         held = high_entries.size() + low_entries.size();
         res.total = held[tpeq_pkg::TOTAL_W-1:0];
         res.all_empty = (held == 0);
         awaited_results.push_back(res);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [tpeq_pkg::RSP_TDATA_W-1:0] tdata,
                                 logic [tpeq_pkg::RSP_TUSER_W-1:0] tuser);
         result_t want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                     $time, tdata, tuser);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("entry_valid", want.entry_valid, tuser[0]);
         compare_field("from_high", want.from_high, tuser[1]);
         compare_field("push_dropped", want.push_dropped, tuser[2]);
         compare_field("all_empty", want.all_empty, tuser[3]);
         compare_field("out_handler_id", want.handler, tdata[15:0]);
         compare_field("out_argument", int'(want.argument), int'($signed(tdata[31:16])));
         compare_field("total_count", want.total, tdata[37:32]);
      endfunction
   endclass

   event_queue_scoreboard sb;

   two_priority_event_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // transfers are taken at the edge on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[1:0], req_tuser[2], req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   initial begin : result_sink
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_request(input logic [tpeq_pkg::ACTION_W-1:0] act, input logic prio,
                               input logic [tpeq_pkg::HANDLER_W-1:0] hid,
                               input logic [tpeq_pkg::ARGUMENT_W-1:0] arg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {arg, hid};
      req_tuser <= {prio, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // random traffic in stretches that fill, drain or churn the queues
   task automatic send_random(input int count);
      int push_pcts[5] = '{90, 90, 90, 10, 55};
      int high_pcts[5] = '{90, 10, 50, 50, 50};
      int mode;
      int pick;
      logic [tpeq_pkg::ACTION_W-1:0] act;
      mode = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) mode = $urandom_range(4);
         pick = $urandom_range(99);
         if (pick < 2) act = ACT_NONE;
         else if (pick < push_pcts[mode]) act = tpeq_pkg::ACT_PUSH;
         else if ($urandom_range(99) < 70) act = tpeq_pkg::ACT_POP;
         else act = tpeq_pkg::ACT_PEEK;
         send_request(act, $urandom_range(99) < high_pcts[mode],
                      16'($urandom_range(16'hffff)), 16'($urandom));
      end
   endtask

   initial begin : stimulus
      int waited;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queues, field extremes, priority order, the unused action
      send_request(tpeq_pkg::ACT_POP, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_PEEK, 1'b1, 16'hffff, 16'hffff);
      send_request(ACT_NONE, 1'b1, 16'hffff, 16'hffff);
      send_request(tpeq_pkg::ACT_PUSH, 1'b0, 16'h0000, 16'h8000);
      send_request(tpeq_pkg::ACT_PUSH, 1'b1, 16'hffff, 16'h7fff);
      send_request(tpeq_pkg::ACT_PEEK, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_PUSH, 1'b0, 16'h1234, 16'h0000);
      send_request(ACT_NONE, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_POP, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_PEEK, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_POP, 1'b1, 16'hffff, 16'hffff);
      send_request(tpeq_pkg::ACT_PUSH, 1'b1, 16'h0000, 16'hffff);
      send_request(tpeq_pkg::ACT_PUSH, 1'b0, 16'hffff, 16'h0001);
      send_request(tpeq_pkg::ACT_POP, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_POP, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_POP, 1'b0, 16'h0000, 16'h0000);
      send_request(tpeq_pkg::ACT_PEEK, 1'b0, 16'h0000, 16'h0000);

      // no idling, with a long result hold-off while requests keep coming
      send_random(100);
      hold_requests++;
      send_random(100);

      send_idle_pct = 59;
      rsp_stall_pct = 0;
      send_random(200);

      send_idle_pct = 0;
      rsp_stall_pct = 59;
      send_random(200);

      send_idle_pct = 15;
      rsp_stall_pct = 15;
      send_random(200);

      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
